[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk, gated by rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/plic_pkg.sv]
// ----------------------------------------------------------------------------
// plic_pkg
// Sizes, register map and codes of the platform interrupt controller.
// ----------------------------------------------------------------------------
package plic_pkg;

  localparam int NUM_SOURCES   = 64;
  localparam int PRIORITY_BITS = 3;
  localparam int CONTEXT_INDEX = 1;

  localparam int ID_W     = $clog2(NUM_SOURCES);
  localparam int WORD_CNT = (NUM_SOURCES + 31) / 32;
  localparam int WORD_W   = (WORD_CNT > 1) ? $clog2(WORD_CNT) : 1;

  localparam int KIND_W = 2;
  localparam int ADDR_W = 26;
  localparam int DATA_W = 32;
  localparam int SRC_W  = 6;

  localparam logic [31:0] PRI_END    = 32'(4 * NUM_SOURCES);
  localparam logic [31:0] PEND_BASE  = 32'h0000_1000;
  localparam logic [31:0] PEND_END   = PEND_BASE + 32'(4 * WORD_CNT);
  localparam logic [31:0] EN_BASE    = 32'h0000_2000 + 32'(CONTEXT_INDEX * 'h80);
  localparam logic [31:0] EN_END     = EN_BASE + 32'(4 * WORD_CNT);
  localparam logic [31:0] THR_ADDR   = 32'h0020_0000 + 32'(CONTEXT_INDEX * 'h1000);
  localparam logic [31:0] CLAIM_ADDR = 32'h0020_0004 + 32'(CONTEXT_INDEX * 'h1000);

  typedef enum logic [KIND_W-1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_REQ   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACT,
    ST_CAPT,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN,
    ST_OUT
  } plic_state_t;

endpackage

[rtl/core/plic_in_if.sv]
// ----------------------------------------------------------------------------
// plic_in_if
// Input channel: bus read, bus write or source request item.
// ----------------------------------------------------------------------------
interface plic_in_if;
  logic                        valid;
  logic                        ready;
  logic [plic_pkg::KIND_W-1:0] kind;
  logic [plic_pkg::ADDR_W-1:0] address;
  logic [plic_pkg::DATA_W-1:0] write_data;
  logic [plic_pkg::SRC_W-1:0]  source_id;

  modport source (output valid, kind, address, write_data, source_id, input ready);
  modport sink   (input valid, kind, address, write_data, source_id, output ready);
endinterface

[rtl/core/plic_out_if.sv]
// ----------------------------------------------------------------------------
// plic_out_if
// Result channel: read data and interrupt line state.
// ----------------------------------------------------------------------------
interface plic_out_if;
  logic                        valid;
  logic                        ready;
  logic [plic_pkg::DATA_W-1:0] read_data;
  logic                        irq_line;

  modport source (output valid, read_data, irq_line, input ready);
  modport sink   (input valid, read_data, irq_line, output ready);
endinterface

[rtl/core/platform_interrupt_controller.sv]
// ----------------------------------------------------------------------------
// platform_interrupt_controller
// One-context interrupt controller on the standard PLIC register map.
// ----------------------------------------------------------------------------
// Each item (bus read, bus write or source request) is taken through the
// states ACT, CAPT, SCAN, DRAIN, FIN and OUT, and its result is held in OUT
// until it is taken; no new item is accepted until then. The pass in SCAN
// goes over the priority RAM, which has a single read port and is read one
// source per cycle (sources 1 to NUM_SOURCES - 1) to find the best enabled
// pending source; that pass runs after every item to refresh irq_line, and
// before the update on a claim read.
`include "assert_macros.svh"

module platform_interrupt_controller (
  input  logic      clk,
  input  logic      rst_n,
  plic_in_if.sink   in_item,
  plic_out_if.source out_item
);

  localparam int N    = plic_pkg::NUM_SOURCES;
  localparam int PW   = plic_pkg::PRIORITY_BITS;
  localparam int IDW  = plic_pkg::ID_W;
  localparam int WC   = plic_pkg::WORD_CNT;
  localparam int WW   = plic_pkg::WORD_W;
  localparam logic [IDW-1:0] LAST_ID = IDW'(N - 1);

  plic_pkg::plic_state_t state_r, state_nxt;

  // latched item
  logic [plic_pkg::KIND_W-1:0] kind_r;
  logic [plic_pkg::ADDR_W-1:0] addr_r;
  logic [plic_pkg::DATA_W-1:0] wdata_r;
  logic [plic_pkg::SRC_W-1:0]  src_r;

  // priority RAM
  logic [PW-1:0]  prio_mem [N];
  logic [N-1:0]   prio_vld_r;
  logic [PW-1:0]  mem_q;
  logic           mem_q_vld_r;
  logic [IDW-1:0] mem_ra;
  logic           mem_we;

  logic [N-1:0]  pending_r, pending_nxt;
  logic [N-1:0]  enable_r, enable_nxt;
  logic [N-1:0]  flight_r, flight_nxt;
  logic [PW-1:0] thr_r, thr_nxt;

  // scan
  logic [IDW-1:0] scan_idx_r, scan_idx_nxt;
  logic           cmp_vld_r;
  logic [IDW-1:0] cmp_idx_r;
  logic [IDW-1:0] best_id_r, best_id_nxt;
  logic [PW-1:0]  best_pri_r, best_pri_nxt;
  logic           any_r, any_nxt;
  logic           multi_r, multi_nxt;
  logic [PW-1:0]  cmp_pri;
  logic           cmp_elig;

  logic [31:0] rdata_r, rdata_nxt;
  logic        irq_r, irq_nxt;

  // decode
  logic [31:0]     addr32, pend_off, en_off, src32;
  logic            aligned, pri_hit, pend_hit, en_hit, thr_hit, clm_hit;
  logic [IDW-1:0]  bus_idx, wd_idx, src_idx;
  logic [WW-1:0]   pend_w, en_w;
  logic            is_read, is_write, is_req, claim_c, wd_ok, src_ok;
  logic [32*WC-1:0] pend_pad, en_pad;

  assign addr32   = 32'(addr_r);
  assign aligned  = (addr_r[1:0] == 2'b00);
  assign pri_hit  = aligned && (addr32 < plic_pkg::PRI_END);
  assign pend_hit = aligned && (addr32 >= plic_pkg::PEND_BASE) && (addr32 < plic_pkg::PEND_END);
  assign en_hit   = aligned && (addr32 >= plic_pkg::EN_BASE) && (addr32 < plic_pkg::EN_END);
  assign thr_hit  = (addr32 == plic_pkg::THR_ADDR);
  assign clm_hit  = (addr32 == plic_pkg::CLAIM_ADDR);
  assign bus_idx  = addr_r[IDW+1:2];
  assign pend_off = addr32 - plic_pkg::PEND_BASE;
  assign en_off   = addr32 - plic_pkg::EN_BASE;
  assign pend_w   = pend_off[WW+1:2];
  assign en_w     = en_off[WW+1:2];

  assign is_read  = (kind_r == plic_pkg::KIND_READ);
  assign is_write = (kind_r == plic_pkg::KIND_WRITE);
  assign is_req   = (kind_r == plic_pkg::KIND_REQ);
  assign claim_c  = is_read && clm_hit;

  assign wd_idx = wdata_r[IDW-1:0];
  assign wd_ok  = (wdata_r != '0) && (wdata_r < 32'(N));
  assign src32   = 32'(src_r);
  assign src_idx = src32[IDW-1:0];
  assign src_ok  = (src_r != '0) && (src32 < 32'(N));

  assign pend_pad = (32*WC)'(pending_r);
  assign en_pad   = (32*WC)'(enable_r);

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      plic_pkg::ST_IDLE:  if (in_item.valid) state_nxt = plic_pkg::ST_ACT;
      plic_pkg::ST_ACT:   state_nxt = plic_pkg::ST_CAPT;
      plic_pkg::ST_CAPT:  state_nxt = plic_pkg::ST_SCAN;
      plic_pkg::ST_SCAN:  if (scan_idx_r == LAST_ID) state_nxt = plic_pkg::ST_DRAIN;
      plic_pkg::ST_DRAIN: state_nxt = plic_pkg::ST_FIN;
      plic_pkg::ST_FIN:   state_nxt = plic_pkg::ST_OUT;
      plic_pkg::ST_OUT:   if (out_item.ready) state_nxt = plic_pkg::ST_IDLE;
      default:            state_nxt = plic_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs
  // --------------------------------------------------------------------------
  always_comb begin
    in_item.ready  = (state_r == plic_pkg::ST_IDLE);
    out_item.valid = (state_r == plic_pkg::ST_OUT);
    mem_ra = (state_r == plic_pkg::ST_SCAN) ? scan_idx_r : bus_idx;
    mem_we = (state_r == plic_pkg::ST_ACT) && is_write && pri_hit && (bus_idx != '0);
  end

  assign out_item.read_data = rdata_r;
  assign out_item.irq_line  = irq_r;

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  assign cmp_pri  = mem_q_vld_r ? mem_q : '0;
  assign cmp_elig = pending_r[cmp_idx_r] && enable_r[cmp_idx_r];

  always_comb begin
    pending_nxt  = pending_r;
    enable_nxt   = enable_r;
    flight_nxt   = flight_r;
    thr_nxt      = thr_r;
    scan_idx_nxt = scan_idx_r;
    best_id_nxt  = best_id_r;
    best_pri_nxt = best_pri_r;
    any_nxt      = any_r;
    multi_nxt    = multi_r;
    rdata_nxt    = rdata_r;
    irq_nxt      = irq_r;

    // shared compare unit, one source per cycle
    if (cmp_vld_r) begin
      if (cmp_elig && (cmp_pri > thr_r)) begin
        multi_nxt = multi_r | any_r;
        any_nxt   = 1'b1;
      end
      if (cmp_elig && (cmp_pri > best_pri_r)) begin
        best_id_nxt  = cmp_idx_r;
        best_pri_nxt = cmp_pri;
      end
    end

    case (state_r)
      plic_pkg::ST_ACT: begin
        for (int s = 1; s < N; s++) begin
          if (is_write && en_hit && (en_w == WW'(s / 32))) enable_nxt[s] = wdata_r[s % 32];
        end
        if (is_write && thr_hit) thr_nxt = wdata_r[PW-1:0];
        if (is_write && clm_hit && wd_ok && enable_r[wd_idx]) flight_nxt[wd_idx] = 1'b0;
        if (is_req && src_ok && !flight_r[src_idx]) pending_nxt[src_idx] = 1'b1;
      end
      plic_pkg::ST_CAPT: begin
        rdata_nxt = '0;
        if (is_read) begin
          if (pri_hit) begin
            rdata_nxt = (bus_idx != '0) ? 32'(cmp_pri) : '0;
          end else if (pend_hit) begin
            rdata_nxt = pend_pad[pend_w*32 +: 32];
          end else if (en_hit) begin
            rdata_nxt = en_pad[en_w*32 +: 32];
          end else if (thr_hit) begin
            rdata_nxt = 32'(thr_r);
          end
        end
        scan_idx_nxt = IDW'(1);
        best_id_nxt  = '0;
        best_pri_nxt = thr_r;
        any_nxt      = 1'b0;
        multi_nxt    = 1'b0;
      end
      plic_pkg::ST_SCAN: begin
        scan_idx_nxt = scan_idx_r + IDW'(1);
      end
      plic_pkg::ST_FIN: begin
        if (claim_c && any_r) begin
          pending_nxt[best_id_r] = 1'b0;
          flight_nxt[best_id_r]  = 1'b1;
          rdata_nxt = 32'(best_id_r);
          irq_nxt   = multi_r;   // claimed source drops out
        end else begin
          irq_nxt = any_r;
        end
      end
      default: ;
    endcase
  end

  // priority RAM, registered read
  always_ff @(posedge clk) begin
    if (mem_we) prio_mem[bus_idx] <= wdata_r[PW-1:0];
    mem_q <= prio_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= plic_pkg::ST_IDLE;
      pending_r   <= '0;
      enable_r    <= '0;
      flight_r    <= '0;
      thr_r       <= '0;
      prio_vld_r  <= '0;
      mem_q_vld_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pending_r   <= pending_nxt;
      enable_r    <= enable_nxt;
      flight_r    <= flight_nxt;
      thr_r       <= thr_nxt;
      if (mem_we) prio_vld_r[bus_idx] <= 1'b1;
      mem_q_vld_r <= prio_vld_r[mem_ra];
      cmp_vld_r   <= (state_r == plic_pkg::ST_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    if (in_item.valid && in_item.ready) begin
      kind_r  <= in_item.kind;
      addr_r  <= in_item.address;
      wdata_r <= in_item.write_data;
      src_r   <= in_item.source_id;
    end
    cmp_idx_r  <= scan_idx_r;
    scan_idx_r <= scan_idx_nxt;
    best_id_r  <= best_id_nxt;
    best_pri_r <= best_pri_nxt;
    any_r      <= any_nxt;
    multi_r    <= multi_nxt;
    rdata_r    <= rdata_nxt;
    irq_r      <= irq_nxt;
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ASSERT_NOW(a_no_overlap, 1'b1, !(in_item.ready && out_item.valid))
  `ASSERT_NOW(a_pend_flight, 1'b1, (pending_r & flight_r) == '0)
  `ASSERT_NEXT(a_claim_mark, (state_r == plic_pkg::ST_FIN) && claim_c && any_r, flight_r[best_id_r] && (rdata_r != '0))

endmodule

[tb/sv/plic_checker.sv]
// ----------------------------------------------------------------------------
// plic_checker
// Watches both channels of the interrupt controller, keeps its own copy of
// priorities, pending, enable and in-flight bits and the threshold, predicts
// read data and irq line for every accepted item and compares in order.
// ----------------------------------------------------------------------------
module plic_checker
  import plic_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  plic_in_if         in_mon,
  plic_out_if        out_mon,
  output int         fail_count,
  output int         outstanding
);

  typedef struct {
    logic [DATA_W-1:0] read_data;
    logic              irq_line;
  } plic_result_t;

  logic [PRIORITY_BITS-1:0] src_prio [NUM_SOURCES];
  logic [NUM_SOURCES-1:0]   pend_vec;
  logic [NUM_SOURCES-1:0]   en_vec;
  logic [NUM_SOURCES-1:0]   busy_vec;
  logic [PRIORITY_BITS-1:0] thr;

  plic_result_t expected_results [$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  // highest priority above threshold wins, lowest id on ties
  function automatic int top_claimable();
    int best;
    logic [PRIORITY_BITS-1:0] best_pri;
    best     = 0;
    best_pri = thr;
    for (int n = 1; n < NUM_SOURCES; n++) begin
      if (pend_vec[n] && en_vec[n] && src_prio[n] > best_pri) begin
        best     = n;
        best_pri = src_prio[n];
      end
    end
    return best;
  endfunction

  function automatic logic [31:0] pack_bits(logic [NUM_SOURCES-1:0] v, int w);
    logic [31:0] r;
    r = '0;
    for (int b = 0; b < 32; b++) begin
      if (w * 32 + b != 0 && w * 32 + b < NUM_SOURCES) r[b] = v[w * 32 + b];
    end
    return r;
  endfunction

  function automatic logic [31:0] read_register(logic [31:0] a);
    int id;
    if (a[1:0] != 2'b00) return '0;
    if (a < PRI_END) return (a[31:2] == 0) ? '0 : 32'(src_prio[a[31:2]]);
    if (a >= PEND_BASE && a < PEND_END) return pack_bits(pend_vec, int'((a - PEND_BASE) >> 2));
    if (a >= EN_BASE && a < EN_END) return pack_bits(en_vec, int'((a - EN_BASE) >> 2));
    if (a == THR_ADDR) return 32'(thr);
    if (a == CLAIM_ADDR) begin
      id = top_claimable();
      if (id != 0) begin
        pend_vec[id] = 1'b0;
        busy_vec[id] = 1'b1;
      end
      return 32'(id);
    end
    return '0;
  endfunction

  function automatic void write_register(logic [31:0] a, logic [31:0] d);
    int w;
    if (a[1:0] != 2'b00) return;
    if (a < PRI_END) begin
      if (a[31:2] != 0) src_prio[a[31:2]] = d[PRIORITY_BITS-1:0];
      return;
    end
    if (a >= EN_BASE && a < EN_END) begin
      w = int'((a - EN_BASE) >> 2);
      for (int b = 0; b < 32; b++) begin
        if (w * 32 + b != 0 && w * 32 + b < NUM_SOURCES) en_vec[w * 32 + b] = d[b];
      end
      return;
    end
    if (a == THR_ADDR) begin
      thr = d[PRIORITY_BITS-1:0];
      return;
    end
    // complete: only a valid, enabled id releases the in-flight mark
    if (a == CLAIM_ADDR) begin
      if (d != 0 && d < NUM_SOURCES && en_vec[d]) busy_vec[d] = 1'b0;
    end
  endfunction

  always @(posedge clk) begin : monitor
    plic_result_t exp_res;
    plic_result_t got_res;
    logic [31:0]  addr;
    int           errs;
    errs = 0;
    if (!rst_n) begin
      for (int n = 0; n < NUM_SOURCES; n++) src_prio[n] = '0;
      pend_vec = '0;
      en_vec   = '0;
      busy_vec = '0;
      thr      = '0;
      expected_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: read_data %h irq_line %b",
                 out_mon.read_data, out_mon.irq_line);
          errs++;
        end else begin
          exp_res = expected_results.pop_front();
          if (out_mon.read_data !== exp_res.read_data) begin
            $error("read_data mismatch: expected %h, actual %h",
                   exp_res.read_data, out_mon.read_data);
            errs++;
          end
          if (out_mon.irq_line !== exp_res.irq_line) begin
            $error("irq_line mismatch: expected %b, actual %b",
                   exp_res.irq_line, out_mon.irq_line);
            errs++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        addr = 32'(in_mon.address);
        got_res.read_data = '0;
        case (in_mon.kind)
          KIND_READ:  got_res.read_data = read_register(addr);
          KIND_WRITE: write_register(addr, in_mon.write_data);
          KIND_REQ: begin
            if (in_mon.source_id != 0 && in_mon.source_id < NUM_SOURCES &&
                !busy_vec[in_mon.source_id])
              pend_vec[in_mon.source_id] = 1'b1;
          end
          default: ;
        endcase
        got_res.irq_line = (top_claimable() != 0);
        expected_results.push_back(got_res);
      end
    end
    fail_count  <= fail_count + errs;
    outstanding <= expected_results.size();
  end

endmodule

[tb/sv/tb_platform_interrupt_controller.sv]
// ----------------------------------------------------------------------------
// tb_platform_interrupt_controller
// Drives bus reads, bus writes and source requests into the interrupt
// controller: a directed pass over the register map corners, then random
// interrupt flows (request, claim, complete) mixed with map noise, under
// three idling profiles. A checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module tb_platform_interrupt_controller;
  import plic_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int LIMIT_CYCLES     = 1_000_000;
  localparam int DRAIN_CYCLES     = NUM_SOURCES + 16;
  localparam int RANDOM_PER_PHASE = 520;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
    logic [SRC_W-1:0]  source_id;
  } plic_item_t;

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   cycle_count = 0;
  int   fail_count;
  int   outstanding;
  int   recent_ids [$];

  plic_in_if  in_item ();
  plic_out_if out_item ();

  platform_interrupt_controller dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .out_item (out_item)
  );

  plic_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_item),
    .out_mon     (out_item),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    out_item.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_item.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic drive_item(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] address,
                            logic [DATA_W-1:0] data, logic [SRC_W-1:0] src);
    while ($urandom_range(99) < send_idle_pct) begin
      in_item.valid <= 1'b0;
      @(posedge clk);
    end
    in_item.valid      <= 1'b1;
    in_item.kind       <= kind;
    in_item.address    <= address;
    in_item.write_data <= data;
    in_item.source_id  <= src;
    do @(posedge clk); while (in_item.ready !== 1'b1);
  endtask

  // mostly request/claim/complete traffic on live sources, some map noise
  function automatic plic_item_t random_item();
    plic_item_t it;
    int pick;
    int id;
    logic [31:0] edge_addr [9];
    edge_addr = '{PRI_END, PEND_BASE - 4, PEND_END, EN_BASE - 4, EN_END,
                  32'h0000_2000, 32'h0020_0000, THR_ADDR, CLAIM_ADDR + 4};
    it.kind       = KIND_READ;
    it.address    = '0;
    it.write_data = $urandom;
    it.source_id  = SRC_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 25) begin
      it.kind = KIND_REQ;
      id = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, NUM_SOURCES - 1);
      it.source_id = SRC_W'(id);
      if (id != 0) recent_ids.push_back(id);
      if (recent_ids.size() > 8) void'(recent_ids.pop_front());
    end else if (pick < 37) begin
      it.kind    = KIND_WRITE;
      it.address = ADDR_W'(4 * $urandom_range(0, NUM_SOURCES - 1));
    end else if (pick < 42) begin
      it.address = ADDR_W'(4 * $urandom_range(0, NUM_SOURCES - 1));
    end else if (pick < 50) begin
      it.kind       = KIND_WRITE;
      it.address    = ADDR_W'(EN_BASE + 4 * $urandom_range(0, WORD_CNT - 1));
      it.write_data = $urandom | $urandom;
    end else if (pick < 54) begin
      it.address = ADDR_W'(EN_BASE + 4 * $urandom_range(0, WORD_CNT - 1));
    end else if (pick < 58) begin
      it.kind    = $urandom_range(1) ? KIND_WRITE : KIND_READ;
      it.address = ADDR_W'(PEND_BASE + 4 * $urandom_range(0, WORD_CNT - 1));
    end else if (pick < 63) begin
      it.kind    = $urandom_range(1) ? KIND_WRITE : KIND_READ;
      it.address = ADDR_W'(THR_ADDR);
      if ($urandom_range(4) != 0)
        it.write_data[PRIORITY_BITS-1:0] = PRIORITY_BITS'($urandom_range(0, 3));
    end else if (pick < 78) begin
      it.address = ADDR_W'(CLAIM_ADDR);
    end else if (pick < 91) begin
      it.kind    = KIND_WRITE;
      it.address = ADDR_W'(CLAIM_ADDR);
      if (recent_ids.size() > 0 && $urandom_range(3) != 0)
        it.write_data = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
      else if ($urandom_range(4) != 0)
        it.write_data = $urandom_range(0, NUM_SOURCES - 1);
    end else if (pick < 96) begin
      it.kind    = $urandom_range(1) ? KIND_WRITE : KIND_READ;
      it.address = ADDR_W'(edge_addr[$urandom_range(0, 8)] + $urandom_range(0, 7));
    end else if (pick < 98) begin
      it.kind    = $urandom_range(1) ? KIND_WRITE : KIND_READ;
      it.address = ADDR_W'($urandom);
    end else begin
      it.kind    = KIND_UNUSED;
      it.address = ADDR_W'($urandom);
    end
    return it;
  endfunction

  initial begin
    plic_item_t it;
    rst_n              <= 1'b0;
    in_item.valid      <= 1'b0;
    in_item.kind       <= '0;
    in_item.address    <= '0;
    in_item.write_data <= '0;
    in_item.source_id  <= '0;
    send_idle_pct = 13;
    recv_idle_pct = 68;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // register map corners and the claim/complete protocol
    drive_item(KIND_WRITE, ADDR_W'(0), 32'h7, '0);
    drive_item(KIND_READ, ADDR_W'(0), '0, '0);
    drive_item(KIND_WRITE, ADDR_W'(4), 32'hFFFF_FFFF, '0);
    drive_item(KIND_WRITE, ADDR_W'(4 * (NUM_SOURCES - 1)), 32'h5, '0);
    drive_item(KIND_READ, ADDR_W'(4), '0, '0);
    drive_item(KIND_WRITE, ADDR_W'(EN_BASE), 32'hFFFF_FFFF, '0);
    drive_item(KIND_WRITE, ADDR_W'(EN_BASE + 4), 32'hFFFF_FFFF, '0);
    drive_item(KIND_READ, ADDR_W'(EN_BASE), '0, '0);
    drive_item(KIND_REQ, '0, '0, 6'd0);
    drive_item(KIND_REQ, '0, '0, 6'd1);
    drive_item(KIND_REQ, '0, '0, SRC_W'(NUM_SOURCES - 1));
    drive_item(KIND_WRITE, ADDR_W'(PEND_BASE), 32'hFFFF_FFFF, '0);
    drive_item(KIND_READ, ADDR_W'(PEND_BASE), '0, '0);
    drive_item(KIND_WRITE, ADDR_W'(THR_ADDR), 32'hFFFF_FFFF, '0);
    drive_item(KIND_READ, ADDR_W'(THR_ADDR), '0, '0);
    drive_item(KIND_READ, ADDR_W'(CLAIM_ADDR), '0, '0);
    drive_item(KIND_WRITE, ADDR_W'(THR_ADDR), 32'h0, '0);
    drive_item(KIND_READ, ADDR_W'(CLAIM_ADDR), '0, '0);
    drive_item(KIND_REQ, '0, '0, 6'd1);
    drive_item(KIND_READ, ADDR_W'(CLAIM_ADDR), '0, '0);
    drive_item(KIND_READ, ADDR_W'(CLAIM_ADDR), '0, '0);
    drive_item(KIND_WRITE, ADDR_W'(CLAIM_ADDR), 32'(NUM_SOURCES), '0);
    drive_item(KIND_WRITE, ADDR_W'(CLAIM_ADDR), 32'h0, '0);
    drive_item(KIND_WRITE, ADDR_W'(EN_BASE), 32'h0, '0);
    drive_item(KIND_WRITE, ADDR_W'(CLAIM_ADDR), 32'h1, '0);
    drive_item(KIND_WRITE, ADDR_W'(EN_BASE), 32'hFFFF_FFFF, '0);
    drive_item(KIND_WRITE, ADDR_W'(CLAIM_ADDR), 32'h1, '0);
    drive_item(KIND_READ, ADDR_W'(5), '0, '0);
    drive_item(KIND_READ, 26'h3FF_FFFC, '0, '0);
    drive_item(KIND_UNUSED, ADDR_W'(CLAIM_ADDR), 32'hFFFF_FFFF, 6'h3F);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 13;
          recv_idle_pct = 68;
        end
        1: begin
          send_idle_pct = 68;
          recv_idle_pct = 13;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        it = random_item();
        drive_item(it.kind, it.address, it.write_data, it.source_id);
      end
    end
    in_item.valid <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
